// ===== sv/mm4_pkg.sv =====
// mm4_pkg: shared types and constants for the 4x4 fixed-point matrix multiplier
// holds the input and result item structs and the accumulate-to-merge control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mm4_pkg;

  localparam int unsigned DIM    = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = $clog2(DIM);
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned ACC_W  = PROD_W + IDX_W;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] a_col0;
    logic signed [DATA_W-1:0] a_col1;
    logic signed [DATA_W-1:0] a_col2;
    logic signed [DATA_W-1:0] a_col3;
    logic signed [DATA_W-1:0] b_col0;
    logic signed [DATA_W-1:0] b_col1;
    logic signed [DATA_W-1:0] b_col2;
    logic signed [DATA_W-1:0] b_col3;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] c_col0;
    logic signed [DATA_W-1:0] c_col1;
    logic signed [DATA_W-1:0] c_col2;
    logic signed [DATA_W-1:0] c_col3;
    logic [1:0]               row_number;
    logic                     last_row;
    logic                     saturated;
  } out_item_t;

  // accumulator stage status handed to the merge stage
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] row;
  } acc_ctl_t;

endpackage

`default_nettype wire

// ===== sv/mm4_lane.sv =====
// mm4_lane: one column lane, holds a column of B and runs a multiply-accumulate
// over the terms of one dot product, then shifts and saturates the sum
// depends on mm4_pkg
`timescale 1ns / 1ps
`default_nettype none

module mm4_lane
  import mm4_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     load_en_i,
  input  wire logic [IDX_W-1:0]         load_row_i,
  input  wire logic signed [DATA_W-1:0] b_i,
  input  wire logic [IDX_W-1:0]         rd_idx_i,
  input  wire logic signed [DATA_W-1:0] a_i,
  input  wire logic                     first_i,
  output logic signed [DATA_W-1:0]      res_o,
  output logic                          clip_o
);

  logic signed [DATA_W-1:0] b_col_q [DIM];
  logic signed [PROD_W-1:0] prod_q;
  logic                     first_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_W:0]    hi_bits;
  logic                     fits;

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      b_col_q[load_row_i] <= b_i;
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    prod_q  <= a_i * b_col_q[rd_idx_i];
    first_q <= first_i;
  end

  assign prod_ext = {{IDX_W{prod_q[PROD_W-1]}}, prod_q};
  assign acc_d    = first_q ? prod_ext : acc_q + prod_ext;

  // accumulate stage, restarts on the first term of each element
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // arithmetic shift then clip to 32 bits
  assign shifted = acc_q >>> FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:DATA_W-1];
  assign fits    = (&hi_bits) | ~(|hi_bits);
  assign clip_o  = ~fits;
  assign res_o   = fits ? shifted[DATA_W-1:0]
                        : (acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX);

endmodule

`default_nettype wire

// ===== sv/mm4_merge.sv =====
// mm4_merge: merges the lane results into one registered result item
// with row number, last mark and row saturation flag
// depends on mm4_pkg
`timescale 1ns / 1ps
`default_nettype none

module mm4_merge
  import mm4_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire acc_ctl_t                     acc_ctl_i,
  input  wire logic [DIM-1:0][DATA_W-1:0]   lane_res_i,
  input  wire logic [DIM-1:0]               lane_clip_i,
  output logic                              out_valid_o,
  output out_item_t                         result_o
);

  logic      valid_q;
  out_item_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= acc_ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_ctl_i.vld) begin
      result_q.c_col0     <= lane_res_i[0];
      result_q.c_col1     <= lane_res_i[1];
      result_q.c_col2     <= lane_res_i[2];
      result_q.c_col3     <= lane_res_i[3];
      result_q.row_number <= acc_ctl_i.row;
      result_q.last_row   <= (acc_ctl_i.row == IDX_W'(DIM - 1));
      result_q.saturated  <= |lane_clip_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// ===== sv/matrix4_multiply_unit.sv =====
// matrix4_multiply_unit: top level of the 4x4 signed Q16.16 matrix multiplier
// instantiates four mm4_lane column lanes and the mm4_merge output stage
// depends on mm4_pkg
//
// a row item that is not the fourth is only stored and gives no result; after the
// fourth row the result rows follow in row order, each once its terms have passed
// the multiply, accumulate and merge registers; busy stays high from the fourth
// row until the last result row has gone out, so no row is taken while it runs
// each lane's single multiplier walks the four terms of a row
// reset clears the row counter, sequencer and result strobe; stores are not cleared
// the receiver cannot stall: each result strobe lasts exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module matrix4_multiply_unit
  import mm4_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire in_item_t  item_i,
  output logic           out_valid_o,
  output out_item_t      result_o
);

  // rows of A, one entry per element, read at one address per cycle
  logic signed [DATA_W-1:0] a_store_q [DIM*DIM];

  logic [IDX_W-1:0] rows_q, rows_d;
  logic             busy_q, busy_d;
  logic             run_q, run_d;
  logic [IDX_W-1:0] h_q, h_d;
  logic [IDX_W-1:0] i_q, i_d;

  // valid/row tracking alongside the lane pipelines
  logic             mvld_q;
  logic             mlast_q;
  logic [IDX_W-1:0] mrow_q;
  acc_ctl_t         actl_q;

  logic accept;
  logic signed [DATA_W-1:0] a_in [DIM];
  logic signed [DATA_W-1:0] b_in [DIM];
  logic signed [DATA_W-1:0] a_rd;
  logic [DIM-1:0][DATA_W-1:0] lane_res;
  logic [DIM-1:0]             lane_clip;

  assign accept = start_i & ~busy_q;

  assign a_in[0] = item_i.a_col0;
  assign a_in[1] = item_i.a_col1;
  assign a_in[2] = item_i.a_col2;
  assign a_in[3] = item_i.a_col3;
  assign b_in[0] = item_i.b_col0;
  assign b_in[1] = item_i.b_col1;
  assign b_in[2] = item_i.b_col2;
  assign b_in[3] = item_i.b_col3;

  // load one row of A per item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int c = 0; c < DIM; c++) begin
        a_store_q[{rows_q, IDX_W'(c)}] <= a_in[c];
      end
    end
  end

  // element a[h][i] goes to all lanes this cycle
  assign a_rd = a_store_q[{h_q, i_q}];

  // sequencer: row counter while loading, then h/i walk over all terms
  always_comb begin
    rows_d = rows_q;
    busy_d = busy_q;
    run_d  = run_q;
    h_d    = h_q;
    i_d    = i_q;
    if (accept) begin
      if (rows_q == IDX_W'(DIM - 1)) begin
        rows_d = '0;
        busy_d = 1'b1;
        run_d  = 1'b1;
        h_d    = '0;
        i_d    = '0;
      end else begin
        rows_d = rows_q + 1'b1;
      end
    end
    if (run_q) begin
      if (i_q == IDX_W'(DIM - 1)) begin
        i_d = '0;
        h_d = h_q + 1'b1;
        if (h_q == IDX_W'(DIM - 1)) begin
          run_d = 1'b0;
        end
      end else begin
        i_d = i_q + 1'b1;
      end
    end
    // free for the next pair once the final row has gone out
    if (out_valid_o && result_o.last_row) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= '0;
      busy_q  <= 1'b0;
      run_q   <= 1'b0;
      h_q     <= '0;
      i_q     <= '0;
      mvld_q  <= 1'b0;
      mlast_q <= 1'b0;
      mrow_q  <= '0;
      actl_q  <= '0;
    end else begin
      rows_q  <= rows_d;
      busy_q  <= busy_d;
      run_q   <= run_d;
      h_q     <= h_d;
      i_q     <= i_d;
      // multiply stage status
      mvld_q  <= run_q;
      mlast_q <= (i_q == IDX_W'(DIM - 1));
      mrow_q  <= h_q;
      // accumulate stage: sum complete after the last term
      actl_q.vld <= mvld_q & mlast_q;
      actl_q.row <= mrow_q;
    end
  end

  assign busy_o = busy_q;

  // one lane per column of B
  for (genvar v = 0; v < DIM; v++) begin : g_lane
    mm4_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .load_en_i (accept),
      .load_row_i(rows_q),
      .b_i       (b_in[v]),
      .rd_idx_i  (i_q),
      .a_i       (a_rd),
      .first_i   (i_q == '0),
      .res_o     (lane_res[v]),
      .clip_o    (lane_clip[v])
    );
  end

  mm4_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_ctl_i  (actl_q),
    .lane_res_i (lane_res),
    .lane_clip_i(lane_clip),
    .out_valid_o(out_valid_o),
    .result_o   (result_o)
  );

endmodule

`default_nettype wire

// ===== sv/mm4_checker.sv =====
// mm4_checker: port-level assertions for matrix4_multiply_unit
// bound to the top level below; depends on mm4_pkg
`timescale 1ns / 1ps
`default_nettype none

module mm4_checker
  import mm4_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start_i,
  input wire logic      busy_o,
  input wire logic      out_valid_o,
  input wire out_item_t result_o
);

  // results only come out of a running product
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("result item outside a busy window");

  // the final row releases the block
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_o.last_row) |=> !busy_o)
    else $error("busy held after last row");

  // busy only rises after an accepted item
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without an accepted item");

  // rows are spaced by the term walk, never back to back
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result rows back to back");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_o.last_row == (result_o.row_number == 2'd3)))
    else $error("last mark not on row three");

endmodule

bind matrix4_multiply_unit mm4_checker u_mm4_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .out_valid_o(out_valid_o),
  .result_o   (result_o)
);

`default_nettype wire
